// File: hdl/vre_pkg.sv
// ----------------------------------------------------------------------------
// vre_pkg
// Shared constants, payload types and control structs of the voice
// resampler envelope unit.
// ----------------------------------------------------------------------------
package vre_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int PHASE_BITS  = 16;
	localparam int MAX_RUN     = 32;

	localparam int RUN_HALF = ((MAX_RUN / 2) < 1) ? 1 : (MAX_RUN / 2);
	localparam int RUN_W    = $clog2(MAX_RUN + 1);

	localparam int RATIO_W = 20;
	localparam logic [RATIO_W-1:0] RATIO_LO =
		RATIO_W'(((1 << PHASE_BITS) + RUN_HALF - 1) / RUN_HALF);
	localparam logic [RATIO_W-1:0] RATIO_HI = RATIO_W'(8 << PHASE_BITS);

	localparam int LEAD_W  = 4;
	localparam int ENV_W   = 16;
	localparam int RATE_W  = 17;
	localparam int GAIN_W  = 24;
	localparam int GSTEP_W = 25;
	localparam int RC_W    = 12;
	localparam int RS_W    = 4;

	localparam logic [ENV_W-1:0]  ENV_FULL = ENV_W'(32768);
	localparam logic [RS_W-1:0]   RS_MAX   = RS_W'(12);
	localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_RATIO   = 3'd0,
		REG_MONO_SOURCE   = 3'd1,
		REG_FADE_IN_STEP  = 3'd2,
		REG_FADE_OUT_STEP = 3'd3,
		REG_RAMP_SHIFT    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN1,
		SEQ_RUN2
	} seq_state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic [15:0]                   voice_gain;
		logic                          stop_request;
		logic                          end_of_stream;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          run_last;
		logic                          voice_done;
	} result_t;

	typedef struct packed {
		logic [RATIO_W-1:0] phase_ratio;
		logic               mono_source;
		logic [15:0]        fade_in_step;
		logic [15:0]        fade_out_step;
		logic [RS_W-1:0]    ramp_shift;
	} cfg_t;

	typedef struct packed {
		logic                          valid;
		logic                          last;
		logic                          done;
		logic signed [SAMPLE_BITS-1:0] a_l;
		logic signed [SAMPLE_BITS-1:0] a_r;
		logic signed [SAMPLE_BITS-1:0] b_l;
		logic signed [SAMPLE_BITS-1:0] b_r;
		logic [PHASE_BITS-1:0]         frac;
		logic [GAIN_W-1:0]             gain;
		logic [ENV_W-1:0]              env;
	} issue_t;

endpackage

// File: hdl/vre_front.sv
// ----------------------------------------------------------------------------
// vre_front
// Input side: takes source frames, applies the mono mapping and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module vre_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mono_source,
	input  logic            frame_valid,
	output logic            frame_stall,
	input  vre_pkg::frame_t frame,
	output logic            q_valid,
	output vre_pkg::frame_t q_head,
	input  logic            q_pop
);

	vre_pkg::frame_t mem_q [2];
	vre_pkg::frame_t mapped;
	logic [1:0]      count_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic            push;

	always_comb begin
		mapped = frame;
		if (mono_source) begin
			mapped.right_sample = frame.left_sample;
		end
	end

	assign frame_stall = (count_q == 2'd2);
	assign push        = frame_valid && !frame_stall;
	assign q_valid     = (count_q != 2'd0);
	assign q_head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= mapped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/vre_seq.sv
// ----------------------------------------------------------------------------
// vre_seq
// Back-end sequencer: pops queued frames, keeps phase, envelope and gain
// ramp state, and issues one output frame per step to the datapath.
// ----------------------------------------------------------------------------
module vre_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  vre_pkg::cfg_t   cfg,
	input  logic            adv,
	input  logic            q_valid,
	input  vre_pkg::frame_t q_head,
	output logic            q_pop,
	output vre_pkg::issue_t issue
);

	localparam int SB = vre_pkg::SAMPLE_BITS;
	localparam int PB = vre_pkg::PHASE_BITS;

	vre_pkg::seq_state_t st_q, st_d;

	logic signed [SB-1:0] prev_l_q, prev_r_q, prev_l_d, prev_r_d;
	logic signed [SB-1:0] cur_l_q, cur_r_q;
	logic [15:0]          cur_gain_q;
	logic                 cur_eos_q;
	logic                 load_cur;

	logic                          have_prev_q, have_prev_d;
	logic [PB-1:0]                 frac_q, frac_d;
	logic [vre_pkg::LEAD_W-1:0]    lead_q, lead_d;
	logic [vre_pkg::ENV_W-1:0]     env_q, env_d;
	logic signed [vre_pkg::RATE_W-1:0]  rate_q, rate_d;
	logic                          stopping_q, stopping_d;
	logic                          finished_q, finished_d;
	logic [vre_pkg::GAIN_W-1:0]    gain_now_q, gain_now_d;
	logic signed [vre_pkg::GSTEP_W-1:0] gain_step_q, gain_step_d;
	logic [vre_pkg::RC_W-1:0]      rc_q, rc_d;
	logic [vre_pkg::RUN_W-1:0]     n_q, n_d;

	logic [vre_pkg::RS_W-1:0]      rs;
	logic [vre_pkg::RATIO_W-1:0]   ratio;
	logic signed [25:0]            gain_diff;
	logic signed [25:0]            gain_neg;
	logic [24:0]                   gain_mag;
	logic [24:0]                   gain_shr;
	logic signed [vre_pkg::GSTEP_W-1:0] gstep_new;
	logic signed [vre_pkg::GSTEP_W-1:0] gstep_eff;
	logic signed [17:0]            env_sum;
	logic                          cap;
	logic signed [17:0]            env_cap;
	logic                          fade_done;
	logic [vre_pkg::ENV_W-1:0]     env_clamp;
	logic signed [25:0]            gain_sum;
	logic [vre_pkg::GAIN_W-1:0]    gain_sat;
	logic [vre_pkg::RC_W-1:0]      rc_mask;
	logic [vre_pkg::RC_W-1:0]      rc_next;
	logic [vre_pkg::RATIO_W:0]     phase_sum;
	logic [vre_pkg::LEAD_W-1:0]    lead_step;
	logic [vre_pkg::LEAD_W-1:0]    lead_dec;
	logic [vre_pkg::RUN_W-1:0]     n_inc;
	logic                          more_room;
	logic                          cont;
	logic [vre_pkg::ENV_W-1:0]     arm_env;
	logic signed [vre_pkg::RATE_W-1:0] arm_rate;
	logic [vre_pkg::RATE_W-1:0]    fall;
	logic signed [vre_pkg::RATE_W-1:0] pre_rate;
	logic [vre_pkg::ENV_W-1:0]     pre_env;

	// step arithmetic
	assign rs    = (cfg.ramp_shift > vre_pkg::RS_MAX) ? vre_pkg::RS_MAX : cfg.ramp_shift;
	assign ratio = (cfg.phase_ratio < vre_pkg::RATIO_LO) ? vre_pkg::RATIO_LO :
		(cfg.phase_ratio > vre_pkg::RATIO_HI) ? vre_pkg::RATIO_HI : cfg.phase_ratio;

	assign gain_diff = $signed({2'b00, cur_gain_q, 8'h00}) - $signed({2'b00, gain_now_q});
	assign gain_neg  = -gain_diff;
	assign gain_mag  = gain_diff[25] ? gain_neg[24:0] : gain_diff[24:0];
	assign gain_shr  = gain_mag >> rs;
	assign gstep_new = gain_diff[25] ? $signed(25'd0 - gain_shr) : $signed(gain_shr);
	assign gstep_eff = (rc_q == '0) ? gstep_new : gain_step_q;

	assign env_sum   = $signed({2'b00, env_q}) + $signed({rate_q[vre_pkg::RATE_W-1], rate_q});
	assign cap       = !rate_q[vre_pkg::RATE_W-1] && (rate_q != '0) &&
		(env_sum >= $signed({2'b00, vre_pkg::ENV_FULL}));
	assign env_cap   = cap ? $signed({2'b00, vre_pkg::ENV_FULL}) : env_sum;
	assign fade_done = stopping_q && (env_cap[17] || (env_cap == '0));
	assign env_clamp = env_cap[17] ? '0 :
		(env_cap > $signed({2'b00, vre_pkg::ENV_FULL})) ? vre_pkg::ENV_FULL : env_cap[15:0];

	assign gain_sum = $signed({2'b00, gain_now_q}) + $signed({gstep_eff[24], gstep_eff});
	assign gain_sat = gain_sum[25] ? '0 : (gain_sum[24] ? vre_pkg::GAIN_MAX : gain_sum[23:0]);

	assign rc_mask = ~({vre_pkg::RC_W{1'b1}} << rs);
	assign rc_next = (rc_q + 1'b1) & rc_mask;

	assign phase_sum = {5'd0, frac_q} + {1'b0, ratio};
	assign lead_step = vre_pkg::LEAD_W'(phase_sum[vre_pkg::RATIO_W:PB]);
	assign lead_dec  = (lead_step == '0) ? '0 : lead_step - 1'b1;
	assign n_inc     = n_q + 1'b1;
	assign more_room = (n_inc < vre_pkg::RUN_W'(vre_pkg::MAX_RUN));
	assign cont      = (lead_step == '0) && more_room;

	// envelope set-up for a popped frame
	assign arm_env  = (cfg.fade_in_step != '0) ? '0 : vre_pkg::ENV_FULL;
	assign arm_rate = (cfg.fade_in_step != '0) ? $signed({1'b0, cfg.fade_in_step}) : '0;
	assign fall     = (cfg.fade_out_step == '0) ? {1'b0, vre_pkg::ENV_FULL} :
		{1'b0, cfg.fade_out_step};
	assign pre_env  = have_prev_q ? env_q : arm_env;
	assign pre_rate = q_head.stop_request ? $signed(-fall) : (have_prev_q ? rate_q : arm_rate);

	always_comb begin
		st_d        = st_q;
		prev_l_d    = prev_l_q;
		prev_r_d    = prev_r_q;
		load_cur    = 1'b0;
		have_prev_d = have_prev_q;
		frac_d      = frac_q;
		lead_d      = lead_q;
		env_d       = env_q;
		rate_d      = rate_q;
		stopping_d  = stopping_q;
		finished_d  = finished_q;
		gain_now_d  = gain_now_q;
		gain_step_d = gain_step_q;
		rc_d        = rc_q;
		n_d         = n_q;
		q_pop       = 1'b0;
		issue       = '0;
		if (adv) begin
			unique case (st_q)
				vre_pkg::SEQ_IDLE: begin
					if (q_valid) begin
						q_pop = 1'b1;
						if (!finished_q) begin
							env_d    = pre_env;
							rate_d   = pre_rate;
							load_cur = 1'b1;
							n_d      = '0;
							if (q_head.stop_request) begin
								stopping_d = 1'b1;
							end
							if (!have_prev_q) begin
								prev_l_d    = q_head.left_sample;
								prev_r_d    = q_head.right_sample;
								have_prev_d = 1'b1;
								if (q_head.end_of_stream) begin
									st_d = vre_pkg::SEQ_RUN2;
								end
							end else if (lead_q == '0) begin
								st_d = vre_pkg::SEQ_RUN1;
							end else begin
								prev_l_d = q_head.left_sample;
								prev_r_d = q_head.right_sample;
								lead_d   = lead_q - 1'b1;
								if (q_head.end_of_stream) begin
									if (lead_q == vre_pkg::LEAD_W'(1)) begin
										st_d = vre_pkg::SEQ_RUN2;
									end else begin
										// stream end with nothing left to play
										issue.valid = 1'b1;
										issue.last  = 1'b1;
										issue.done  = 1'b1;
										finished_d  = 1'b1;
									end
								end
							end
						end
					end
				end
				vre_pkg::SEQ_RUN1, vre_pkg::SEQ_RUN2: begin
					gain_step_d = gstep_eff;
					if (fade_done) begin
						// fade-out reached zero
						env_d       = '0;
						finished_d  = 1'b1;
						issue.valid = 1'b1;
						issue.last  = 1'b1;
						issue.done  = 1'b1;
						st_d        = vre_pkg::SEQ_IDLE;
					end else begin
						env_d       = env_clamp;
						rate_d      = cap ? '0 : rate_q;
						issue.valid = 1'b1;
						issue.a_l   = prev_l_q;
						issue.a_r   = prev_r_q;
						issue.b_l   = (st_q == vre_pkg::SEQ_RUN1) ? cur_l_q : prev_l_q;
						issue.b_r   = (st_q == vre_pkg::SEQ_RUN1) ? cur_r_q : prev_r_q;
						issue.frac  = frac_q;
						issue.gain  = gain_now_q;
						issue.env   = env_clamp;
						gain_now_d  = gain_sat;
						rc_d        = rc_next;
						frac_d      = phase_sum[PB-1:0];
						lead_d      = lead_step;
						n_d         = n_inc;
						if (!cont) begin
							if (st_q == vre_pkg::SEQ_RUN1) begin
								prev_l_d = cur_l_q;
								prev_r_d = cur_r_q;
								lead_d   = lead_dec;
								if (cur_eos_q && (lead_dec == '0) && more_room) begin
									st_d = vre_pkg::SEQ_RUN2;
								end else begin
									issue.last = 1'b1;
									st_d       = vre_pkg::SEQ_IDLE;
									if (cur_eos_q) begin
										issue.done = 1'b1;
										finished_d = 1'b1;
									end
								end
							end else begin
								issue.last = 1'b1;
								issue.done = 1'b1;
								finished_d = 1'b1;
								st_d       = vre_pkg::SEQ_IDLE;
							end
						end
					end
				end
				default: st_d = vre_pkg::SEQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prev_l_q <= prev_l_d;
		prev_r_q <= prev_r_d;
		if (load_cur) begin
			cur_l_q    <= q_head.left_sample;
			cur_r_q    <= q_head.right_sample;
			cur_gain_q <= q_head.voice_gain;
			cur_eos_q  <= q_head.end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= vre_pkg::SEQ_IDLE;
			have_prev_q <= 1'b0;
			frac_q      <= '0;
			lead_q      <= '0;
			env_q       <= vre_pkg::ENV_FULL;
			rate_q      <= '0;
			stopping_q  <= 1'b0;
			finished_q  <= 1'b0;
			gain_now_q  <= '0;
			gain_step_q <= '0;
			rc_q        <= '0;
			n_q         <= '0;
		end else begin
			st_q        <= st_d;
			have_prev_q <= have_prev_d;
			frac_q      <= frac_d;
			lead_q      <= lead_d;
			env_q       <= env_d;
			rate_q      <= rate_d;
			stopping_q  <= stopping_d;
			finished_q  <= finished_d;
			gain_now_q  <= gain_now_d;
			gain_step_q <= gain_step_d;
			rc_q        <= rc_d;
			n_q         <= n_d;
		end
	end

`ifndef SYNTHESIS
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("voice left the finished state");
	a_run_needs_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != vre_pkg::SEQ_IDLE) |-> (have_prev_q && !finished_q))
		else $error("run step without a held frame or after voice end");
	a_run_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != vre_pkg::SEQ_IDLE) |-> (lead_q == '0))
		else $error("run step while read position is ahead");
`endif

endmodule

// File: hdl/vre_dp.sv
// ----------------------------------------------------------------------------
// vre_dp
// Output datapath: interpolation, gain and envelope scaling with rounding,
// saturation and the result register. Stalls as a whole on result_stall.
// ----------------------------------------------------------------------------
module vre_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  vre_pkg::issue_t  issue,
	output logic             adv,
	output logic             result_valid,
	input  logic             result_stall,
	output vre_pkg::result_t result
);

	localparam int SB = vre_pkg::SAMPLE_BITS;
	localparam int PB = vre_pkg::PHASE_BITS;
	localparam logic signed [57:0] ROUND_HALF = 58'sd1 <<< 37;

	logic             v_s1, v_s2, v_s3, out_valid_q;
	vre_pkg::issue_t  iss_s1;
	vre_pkg::result_t result_q;

	// stage 1: difference times phase, gain times envelope
	logic signed [SB:0]     diff_l, diff_r;
	logic signed [SB+PB+1:0] prod_l, prod_r;
	logic [39:0]            ge;

	logic signed [SB+PB+1:0] prod_l_s2, prod_r_s2;
	logic signed [SB-1:0]    a_l_s2, a_r_s2;
	logic [39:0]             ge_s2;
	logic                    last_s2, done_s2;

	assign diff_l = $signed({iss_s1.b_l[SB-1], iss_s1.b_l}) - $signed({iss_s1.a_l[SB-1], iss_s1.a_l});
	assign diff_r = $signed({iss_s1.b_r[SB-1], iss_s1.b_r}) - $signed({iss_s1.a_r[SB-1], iss_s1.a_r});
	assign prod_l = diff_l * $signed({1'b0, iss_s1.frac});
	assign prod_r = diff_r * $signed({1'b0, iss_s1.frac});
	assign ge     = {16'd0, iss_s1.gain} * {24'd0, iss_s1.env};

	// stage 2: interpolated sample times split gain product
	logic signed [SB+1:0]  interp_lw, interp_rw;
	logic signed [SB-1:0]  interp_l, interp_r;
	logic signed [20:0]    ge_hi, ge_lo;
	logic signed [36:0]    phi_l, plo_l, phi_r, plo_r;

	logic signed [36:0]    phi_l_s3, plo_l_s3, phi_r_s3, plo_r_s3;
	logic                  last_s3, done_s3;

	assign interp_lw = $signed({{2{a_l_s2[SB-1]}}, a_l_s2}) + prod_l_s2[SB+PB+1:PB];
	assign interp_rw = $signed({{2{a_r_s2[SB-1]}}, a_r_s2}) + prod_r_s2[SB+PB+1:PB];
	assign interp_l  = interp_lw[SB-1:0];
	assign interp_r  = interp_rw[SB-1:0];
	assign ge_hi     = $signed({1'b0, ge_s2[39:20]});
	assign ge_lo     = $signed({1'b0, ge_s2[19:0]});
	assign phi_l     = interp_l * ge_hi;
	assign plo_l     = interp_l * ge_lo;
	assign phi_r     = interp_r * ge_hi;
	assign plo_r     = interp_r * ge_lo;

	// stage 3: recombine, round, saturate
	logic signed [57:0] tot_l, tot_r;
	logic signed [19:0] v_l, v_r;
	logic signed [SB-1:0] sat_l, sat_r;

	assign tot_l = $signed({phi_l_s3[36], phi_l_s3, 20'd0}) +
		$signed({{21{plo_l_s3[36]}}, plo_l_s3}) + ROUND_HALF;
	assign tot_r = $signed({phi_r_s3[36], phi_r_s3, 20'd0}) +
		$signed({{21{plo_r_s3[36]}}, plo_r_s3}) + ROUND_HALF;
	assign v_l = tot_l[57:38];
	assign v_r = tot_r[57:38];

	always_comb begin
		sat_l = v_l[SB-1:0];
		sat_r = v_r[SB-1:0];
		if (v_l > 20'sd32767) begin
			sat_l = 16'sh7fff;
		end else if (v_l < -20'sd32768) begin
			sat_l = -16'sh8000;
		end
		if (v_r > 20'sd32767) begin
			sat_r = 16'sh7fff;
		end else if (v_r < -20'sd32768) begin
			sat_r = -16'sh8000;
		end
	end

	assign adv          = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			iss_s1    <= issue;
			prod_l_s2 <= prod_l;
			prod_r_s2 <= prod_r;
			a_l_s2    <= iss_s1.a_l;
			a_r_s2    <= iss_s1.a_r;
			ge_s2     <= ge;
			last_s2   <= iss_s1.last;
			done_s2   <= iss_s1.done;
			phi_l_s3  <= phi_l;
			plo_l_s3  <= plo_l;
			phi_r_s3  <= phi_r;
			plo_r_s3  <= plo_r;
			last_s3   <= last_s2;
			done_s3   <= done_s2;
			result_q.left_out   <= sat_l;
			result_q.right_out  <= sat_r;
			result_q.run_last   <= last_s3;
			result_q.voice_done <= done_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && done_s3) |-> last_s3)
		else $error("voice end not on the last result of an item");
`endif

endmodule

// File: hdl/voice_resampler_envelope_unit.sv
// ----------------------------------------------------------------------------
// voice_resampler_envelope_unit
// Single voice renderer: linear interpolation resampling of stereo frames,
// fade envelope, block gain ramp and 16-bit saturation.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  frame    | frame_valid / frame_stall  | vre_pkg::frame_t
//  result   | result_valid / result_stall| vre_pkg::result_t
//  cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  the sequencer pops an item, then issues one result per step (up to 32)
//  while result_stall lets it advance; each result then passes through the
//  multiply pipeline registers and the result register
//  a two-item queue lets the input side keep taking items while the back end
//  works or waits
//  result_stall freezes the whole back end; cfg_ready is always high
//  reset clears all control state and loads the register defaults
// ----------------------------------------------------------------------------
module voice_resampler_envelope_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             frame_valid,
	output logic                             frame_stall,
	input  vre_pkg::frame_t                  frame,
	output logic                             result_valid,
	input  logic                             result_stall,
	output vre_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vre_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vre_pkg::CFG_DATA_W-1:0]   cfg_data
);

	vre_pkg::cfg_t   cfg_q;
	vre_pkg::frame_t q_head;
	vre_pkg::issue_t issue;
	logic            q_valid;
	logic            q_pop;
	logic            adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ratio   <= vre_pkg::RATIO_W'(65536);
			cfg_q.mono_source   <= 1'b0;
			cfg_q.fade_in_step  <= 16'd0;
			cfg_q.fade_out_step <= 16'd14;
			cfg_q.ramp_shift    <= vre_pkg::RS_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vre_pkg::REG_PHASE_RATIO:   cfg_q.phase_ratio   <= cfg_data[vre_pkg::RATIO_W-1:0];
				vre_pkg::REG_MONO_SOURCE:   cfg_q.mono_source   <= cfg_data[0];
				vre_pkg::REG_FADE_IN_STEP:  cfg_q.fade_in_step  <= cfg_data[15:0];
				vre_pkg::REG_FADE_OUT_STEP: cfg_q.fade_out_step <= cfg_data[15:0];
				vre_pkg::REG_RAMP_SHIFT:    cfg_q.ramp_shift    <= cfg_data[vre_pkg::RS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.mono_source (cfg_q.mono_source),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	vre_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.adv     (adv),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.issue   (issue)
	);

	vre_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.issue        (issue),
		.adv          (adv),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: verif/vre_render_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vre_render_check
// Watches the frame, result and register channels of the voice renderer.
// Keeps its own copy of the registers and voice state, works out the output
// frames that each accepted source frame should give, and compares every
// accepted output item field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module vre_render_check
	import vre_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	input  logic                  frame_stall,
	input  frame_t                frame,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  result_t               result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	localparam longint FULL_LEVEL = 32768;
	localparam longint PHASE_ONE  = longint'(1) << PHASE_BITS;
	localparam longint GAIN_TOP   = 64'h0000_0000_00FF_FFFF;
	localparam longint ROUND_HALF = longint'(1) << 37;

	logic [RATIO_W-1:0] ratio_reg;
	logic               mono_reg;
	logic [15:0]        rise_reg;
	logic [15:0]        fall_reg;
	logic [RS_W-1:0]    shift_reg;

	logic signed [SAMPLE_BITS-1:0] hist_l, hist_r;
	logic                          primed;
	logic [PHASE_BITS-1:0]         frac;
	logic [LEAD_W-1:0]             lead;
	logic [ENV_W-1:0]              env;
	logic signed [RATE_W-1:0]      env_slope;
	logic                          fading;
	logic                          ended;
	logic [GAIN_W-1:0]             gain_now;
	logic signed [GSTEP_W-1:0]     gain_inc;
	logic [RC_W-1:0]               ramp_pos;

	result_t span_outs[$];
	result_t due_outputs[$];

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t vre_render_check: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void arm_fade();
		if (rise_reg != 0) begin
			env       = '0;
			env_slope = RATE_W'(int'(rise_reg));
		end else begin
			env       = ENV_W'(FULL_LEVEL);
			env_slope = '0;
		end
	endfunction

	function automatic void clear_voice();
		ratio_reg = RATIO_W'(65536);
		mono_reg  = 1'b0;
		rise_reg  = '0;
		fall_reg  = 16'd14;
		shift_reg = RS_W'(8);
		hist_l    = '0;
		hist_r    = '0;
		primed    = 1'b0;
		frac      = '0;
		lead      = '0;
		fading    = 1'b0;
		ended     = 1'b0;
		gain_now  = '0;
		gain_inc  = '0;
		ramp_pos  = '0;
		arm_fade();
	endfunction

	function automatic void note_output(input logic [15:0] l, input logic [15:0] r,
			input logic done);
		result_t o;
		o.left_out   = l;
		o.right_out  = r;
		o.run_last   = 1'b0;
		o.voice_done = done;
		span_outs.insert(span_outs.size(), o);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] scaled(input longint s, input longint e);
		longint v;
		v = (s * longint'(gain_now) * e + ROUND_HALF) >>> 38;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[SAMPLE_BITS-1:0];
	endfunction

	// interpolate a..b until the phase passes b, the run fills or the voice ends
	task automatic render_span(input longint al, input longint ar, input longint bl,
			input longint br, input logic [15:0] g);
		int     rs;
		longint ratio, d, e, f, sl, sr, g_next, p;
		rs    = (shift_reg > RS_MAX) ? int'(RS_MAX) : int'(shift_reg);
		ratio = longint'(ratio_reg);
		if (ratio < longint'(RATIO_LO))
			ratio = longint'(RATIO_LO);
		if (ratio > longint'(RATIO_HI))
			ratio = longint'(RATIO_HI);
		while (lead == 0 && !ended && span_outs.size() < MAX_RUN) begin
			if (ramp_pos == 0) begin
				d = (longint'(g) << 8) - longint'(gain_now);
				gain_inc = (d >= 0) ? GSTEP_W'(d >>> rs) : GSTEP_W'(-((-d) >>> rs));
			end
			e = longint'(env) + longint'(env_slope);
			if (env_slope > 0 && e >= FULL_LEVEL) begin
				e         = FULL_LEVEL;
				env_slope = '0;
			end
			if (e <= 0 && fading) begin
				env   = '0;
				ended = 1'b1;
				note_output('0, '0, 1'b1);
				return;
			end
			if (e < 0)
				e = 0;
			if (e > FULL_LEVEL)
				e = FULL_LEVEL;
			env = ENV_W'(e);
			f  = longint'(frac);
			sl = (al * (PHASE_ONE - f) + bl * f) >>> PHASE_BITS;
			sr = (ar * (PHASE_ONE - f) + br * f) >>> PHASE_BITS;
			note_output(scaled(sl, e), scaled(sr, e), 1'b0);
			g_next = longint'(gain_now) + longint'(gain_inc);
			if (g_next < 0)
				g_next = 0;
			if (g_next > GAIN_TOP)
				g_next = GAIN_TOP;
			gain_now = GAIN_W'(g_next);
			ramp_pos = RC_W'((int'(ramp_pos) + 1) & ((1 << rs) - 1));
			p    = longint'(frac) + ratio;
			frac = p[PHASE_BITS-1:0];
			lead = lead + LEAD_W'(p >>> PHASE_BITS);
		end
	endtask

	task automatic render_frame(input frame_t f);
		longint l, r;
		span_outs.delete();
		if (ended)
			return;
		l = longint'($signed(f.left_sample));
		r = mono_reg ? l : longint'($signed(f.right_sample));
		if (!primed)
			arm_fade();
		if (f.stop_request) begin
			fading    = 1'b1;
			env_slope = (fall_reg == 0) ? -RATE_W'(FULL_LEVEL) : -RATE_W'(int'(fall_reg));
		end
		if (!primed) begin
			hist_l = SAMPLE_BITS'(l);
			hist_r = SAMPLE_BITS'(r);
			primed = 1'b1;
		end else begin
			if (lead == 0)
				render_span(longint'(hist_l), longint'(hist_r), l, r, f.voice_gain);
			if (!ended) begin
				hist_l = SAMPLE_BITS'(l);
				hist_r = SAMPLE_BITS'(r);
				if (lead != 0)
					lead = lead - 1'b1;
			end
		end
		// end of stream: hold the last frame until the phase passes it
		if (f.end_of_stream && !ended) begin
			if (lead == 0)
				render_span(longint'(hist_l), longint'(hist_r), longint'(hist_l),
					longint'(hist_r), f.voice_gain);
			if (!ended) begin
				ended = 1'b1;
				if (span_outs.size() > 0)
					span_outs[span_outs.size()-1].voice_done = 1'b1;
				else
					note_output('0, '0, 1'b1);
			end
		end
		if (span_outs.size() > 0)
			span_outs[span_outs.size()-1].run_last = 1'b1;
		foreach (span_outs[i])
			due_outputs.insert(due_outputs.size(), span_outs[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_voice();
			due_outputs.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE_RATIO:   ratio_reg = cfg_data[RATIO_W-1:0];
					REG_MONO_SOURCE:   mono_reg  = cfg_data[0];
					REG_FADE_IN_STEP:  rise_reg  = cfg_data[15:0];
					REG_FADE_OUT_STEP: fall_reg  = cfg_data[15:0];
					REG_RAMP_SHIFT:    shift_reg = cfg_data[RS_W-1:0];
					default: ;
				endcase
			end
			if (frame_valid && !frame_stall)
				render_frame(frame);
			if (result_valid && !result_stall) begin
				if (due_outputs.size() == 0) begin
					flag_mismatch("output item with nothing due, left_out",
						longint'($signed(result.left_out)), 0);
				end else begin
					want = due_outputs.pop_front();
					if (result.left_out !== want.left_out)
						flag_mismatch("left_out", longint'($signed(result.left_out)),
							longint'($signed(want.left_out)));
					if (result.right_out !== want.right_out)
						flag_mismatch("right_out", longint'($signed(result.right_out)),
							longint'($signed(want.right_out)));
					if (result.run_last !== want.run_last)
						flag_mismatch("run_last", longint'(result.run_last),
							longint'(want.run_last));
					if (result.voice_done !== want.voice_done)
						flag_mismatch("voice_done", longint'(result.voice_done),
							longint'(want.voice_done));
				end
			end
			outstanding <= due_outputs.size();
		end
	end

endmodule

// File: verif/voice_resampler_envelope_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_resampler_envelope_unit_tb
// Drives one voice through the renderer: a short directed run over sample,
// gain and phase ratio extremes, then randomised phases under changing
// register settings, and finally one way of ending the voice. The sender
// works in bursts, the receiver stalls at random and once holds off long
// enough to back the block up. Checking is done by vre_render_check.
// ----------------------------------------------------------------------------
module voice_resampler_envelope_unit_tb;
	import vre_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 75;

	logic                  clk;
	logic                  arst_n;
	logic                  frame_valid;
	logic                  frame_stall;
	frame_t                frame;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	logic                  hold_off_req;
	int                    burst_left;

	voice_resampler_envelope_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	vre_render_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("voice_resampler_envelope_unit_tb NOT OK");
		$finish;
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin : receiver
		int  seg, mode;
		logic held;
		held = 1'b0;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				seg  = $urandom_range(1, 40);
				repeat (seg) begin
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= ($urandom_range(0, 1) == 0);
						default: result_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic frame_t frame_of(input int l, input int r, input int g,
			input logic stop, input logic eos);
		frame_t f;
		f.left_sample   = l[SAMPLE_BITS-1:0];
		f.right_sample  = r[SAMPLE_BITS-1:0];
		f.voice_gain    = g[15:0];
		f.stop_request  = stop;
		f.end_of_stream = eos;
		return f;
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic frame_t random_frame(input logic stop, input logic eos);
		int g;
		case ($urandom_range(0, 7))
			0: g = 0;
			1: g = 65535;
			default: g = $urandom_range(0, 65535);
		endcase
		return frame_of(rand_sample(), rand_sample(), g, stop, eos);
	endfunction

	task automatic send_frame(input frame_t f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				frame_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		frame       <= f;
		frame_valid <= 1'b1;
		do @(posedge clk); while (frame_stall);
	endtask

	task automatic drain_and_settle();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// unused upper data bits carry junk
	task automatic set_voice_regs(input logic [RATIO_W-1:0] ratio, input logic mono,
			input logic [15:0] rise, input logic [15:0] fall, input logic [RS_W-1:0] shift);
		logic [CFG_DATA_W-1:0] junk;
		drain_and_settle();
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_PHASE_RATIO, ratio);
		write_reg(REG_MONO_SOURCE, {junk[19:1], mono});
		write_reg(REG_FADE_IN_STEP, {junk[19:16], rise});
		write_reg(REG_FADE_OUT_STEP, {junk[3:0], fall});
		write_reg(REG_RAMP_SHIFT, {junk[15:0], shift});
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0]        rise0;
		logic [RATIO_W-1:0] ratio;
		arst_n       <= 1'b0;
		frame_valid  <= 1'b0;
		frame        <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_PHASE_RATIO;
		cfg_data     <= '0;
		hold_off_req <= 1'b0;
		burst_left   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		case ($urandom_range(0, 2))
			0: rise0 = 16'd0;
			1: rise0 = 16'd32768;
			default: rise0 = 16'($urandom_range(1, 4000));
		endcase

		// four outputs per frame, gain follows at once
		set_voice_regs(20'd16384, 1'b0, rise0, 16'd32768, 4'd0);
		send_frame(frame_of(0, 0, 0, 1'b0, 1'b0));
		send_frame(frame_of(32767, -32768, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-32768, 32767, 65535, 1'b0, 1'b0));
		send_frame(frame_of(32767, 32767, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-32768, -32768, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-1, 1, 32768, 1'b0, 1'b0));
		send_frame(frame_of(21845, -21846, 1, 1'b0, 1'b0));
		send_frame(frame_of(-32768, 32767, 0, 1'b0, 1'b0));

		// ratio below range, mono, ramp shift above the cap
		set_voice_regs(20'd0, 1'b1, 16'd1, 16'd1, 4'd15);
		send_frame(frame_of(32767, -1, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-32768, 0, 65535, 1'b0, 1'b0));
		send_frame(frame_of(12345, -32768, 0, 1'b0, 1'b0));
		send_frame(frame_of(-1, 32767, 65535, 1'b0, 1'b0));
		send_frame(frame_of(0, -32768, 40000, 1'b0, 1'b0));

		// ratio above range: most frames give nothing
		set_voice_regs(20'hFFFFF, 1'b0, 16'd32768, 16'd1, 4'd12);
		send_frame(frame_of(32767, -32768, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-32768, 32767, 0, 1'b0, 1'b0));
		send_frame(frame_of(1, -1, 65535, 1'b0, 1'b0));
		send_frame(frame_of(100, -100, 65535, 1'b0, 1'b0));
		send_frame(frame_of(32767, 32767, 65535, 1'b0, 1'b0));
		send_frame(frame_of(-32768, -32768, 65535, 1'b0, 1'b0));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: ratio = RATIO_W'($urandom_range(4096, 32768));
				1: ratio = RATIO_W'($urandom_range(32768, 131072));
				2: ratio = RATIO_W'($urandom_range(131072, 524288));
				3: ratio = RATIO_W'($urandom_range(0, 4095));
				default: ratio = RATIO_W'($urandom_range(524289, 20'hFFFFF));
			endcase
			set_voice_regs(ratio, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 32768)),
				16'($urandom_range(1, 32768)), RS_W'($urandom_range(0, 15)));
			if (ph == 1)
				hold_off_req <= 1'b1;
			repeat (PHASE_ITEMS) send_frame(random_frame(1'b0, 1'b0));
		end

		case ($urandom_range(0, 2))
			0: begin
				// zero fall step stops the voice at once
				set_voice_regs(20'd16384, 1'b0, 16'd0, 16'd0, 4'd2);
				send_frame(random_frame(1'b1, 1'b0));
			end
			1: begin
				set_voice_regs(RATIO_W'($urandom_range(4096, 65536)), 1'($urandom_range(0, 1)),
					16'd0, 16'($urandom_range(1024, 8192)), RS_W'($urandom_range(0, 12)));
				send_frame(random_frame(1'b1, 1'b0));
				send_frame(random_frame(1'b1, 1'b0));
				repeat (12) send_frame(random_frame(1'b0, 1'b0));
				send_frame(random_frame(1'b0, 1'b1));
			end
			default: begin
				ratio = ($urandom_range(0, 1) == 0) ? 20'h80000
					: RATIO_W'($urandom_range(4096, 65536));
				set_voice_regs(ratio, 1'($urandom_range(0, 1)), 16'd0,
					16'($urandom_range(1, 32768)), RS_W'($urandom_range(0, 12)));
				repeat (4) send_frame(random_frame(1'b0, 1'b0));
				send_frame(random_frame(1'b0, 1'b1));
			end
		endcase
		// voice has ended: these are ignored
		for (int k = 0; k < 4; k++)
			send_frame(random_frame(k[0], k[1]));

		frame_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("voice_resampler_envelope_unit_tb OK");
		else
			$display("voice_resampler_envelope_unit_tb NOT OK");
		$finish;
	end

endmodule
